// ===== sv/plst_pkg.sv =====
// Shared types and constants for the positional list store.
package plst_pkg;

  localparam int CAPACITY      = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int DATA_W        = 32;
  localparam int MODE_W        = 3;
  localparam int POS_W         = 5;
  localparam int COUNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int STATUS_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND      = 3'd0,
    MODE_REMOVE_LAST = 3'd1,
    MODE_INSERT      = 3'd2,
    MODE_ERASE       = 3'd3,
    MODE_READ        = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_APPEND = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_ERASE  = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    exec;
    op_e     op;
    status_e status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_e mode;
    logic  is_full;
    logic  is_empty;
    logic  ins_pos_ok;
    logic  idx_pos_ok;
  } stat_t;

endpackage

// ===== sv/plst_if.sv =====
// Request and response channel interfaces for the positional list store.
interface plst_req_if;
  logic                              valid;
  logic                              ready;
  logic [plst_pkg::MODE_W-1:0]       mode;
  logic [plst_pkg::POS_W-1:0]        position;
  logic signed [plst_pkg::DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface plst_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [plst_pkg::DATA_W-1:0]   read_value;
  logic [plst_pkg::COUNT_W-1:0]         entry_count;
  logic [plst_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input entry_count, input status,
                  output ready);
endinterface

// ===== sv/plst_ctrl.sv =====
// Controller: request capture, operation decode and response valid tracking.
module plst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  plst_pkg::stat_t stat_i,
  output plst_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.op     = plst_pkg::OP_NONE;
    cmd_o.status = plst_pkg::STATUS_OK;
    req_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // decode against the captured request
    case (stat_i.mode)
      plst_pkg::MODE_APPEND: begin
        if (stat_i.is_full) cmd_o.status = plst_pkg::STATUS_FULL;
        else                cmd_o.op     = plst_pkg::OP_APPEND;
      end
      plst_pkg::MODE_REMOVE_LAST: begin
        if (stat_i.is_empty) cmd_o.status = plst_pkg::STATUS_EMPTY;
        else                 cmd_o.op     = plst_pkg::OP_POP;
      end
      plst_pkg::MODE_INSERT: begin
        if (!stat_i.ins_pos_ok)  cmd_o.status = plst_pkg::STATUS_RANGE;
        else if (stat_i.is_full) cmd_o.status = plst_pkg::STATUS_FULL;
        else                     cmd_o.op     = plst_pkg::OP_INSERT;
      end
      plst_pkg::MODE_ERASE: begin
        if (!stat_i.idx_pos_ok) cmd_o.status = plst_pkg::STATUS_RANGE;
        else                    cmd_o.op     = plst_pkg::OP_ERASE;
      end
      plst_pkg::MODE_READ: begin
        if (!stat_i.idx_pos_ok) cmd_o.status = plst_pkg::STATUS_RANGE;
        else                    cmd_o.op     = plst_pkg::OP_READ;
      end
      default: begin
        cmd_o.op     = plst_pkg::OP_NONE;
        cmd_o.status = plst_pkg::STATUS_OK;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_ready_i) out_valid_d = 1'b0;
    if (cmd_o.exec)  out_valid_d = 1'b1;
  end

  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/plst_dp.sv =====
// Datapath: request registers, shifting entry cells, count and response registers.
module plst_dp #(
  parameter int ELEMENT_WIDTH = plst_pkg::ELEMENT_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [plst_pkg::MODE_W-1:0]           mode_i,
  input  logic [plst_pkg::POS_W-1:0]            position_i,
  input  logic signed [plst_pkg::DATA_W-1:0]    value_i,
  input  plst_pkg::cmd_t                        cmd_i,
  output plst_pkg::stat_t                       stat_o,
  output logic signed [plst_pkg::DATA_W-1:0]    read_value_o,
  output logic [plst_pkg::COUNT_W-1:0]          entry_count_o,
  output logic [plst_pkg::STATUS_W-1:0]         status_o
);

  localparam int CAP   = plst_pkg::CAPACITY;
  localparam int POS_W = plst_pkg::POS_W;
  localparam int CNT_W = plst_pkg::COUNT_W;
  localparam int IDX_W = plst_pkg::IDX_W;
  localparam int DW    = plst_pkg::DATA_W;

  plst_pkg::mode_e             mode_q;
  logic [POS_W-1:0]            pos_q;
  logic [ELEMENT_WIDTH-1:0]    value_q;
  logic [ELEMENT_WIDTH-1:0]    value_d;
  logic [ELEMENT_WIDTH-1:0]    mem_q [CAP];
  logic [CNT_W-1:0]            count_q, count_d;
  logic [DW-1:0]               read_value_q;
  logic [DW-1:0]               rd_ext;
  plst_pkg::status_e           status_q;
  logic [IDX_W-1:0]            rd_idx;

  // element width adaptation on the way in and out
  if (ELEMENT_WIDTH >= DW) begin : g_wide
    assign value_d = ELEMENT_WIDTH'(unsigned'(value_i));
    assign rd_ext  = mem_q[rd_idx][DW-1:0];
  end else begin : g_narrow
    assign value_d = value_i[ELEMENT_WIDTH-1:0];
    assign rd_ext  = DW'(mem_q[rd_idx]);
  end

  assign rd_idx = IDX_W'(pos_q - POS_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= plst_pkg::mode_e'(mode_i);
      pos_q   <= position_i;
      value_q <= value_d;
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.is_full    = (count_q == CNT_W'(CAP));
    stat_o.is_empty   = (count_q == '0);
    stat_o.ins_pos_ok = (pos_q != '0) &&
                        ({1'b0, pos_q} <= ({1'b0, POS_W'(count_q)} + (POS_W+1)'(1)));
    stat_o.idx_pos_ok = (pos_q != '0) && (POS_W'(pos_q) <= POS_W'(count_q));
  end

  // entry cells, each loading from itself, a neighbor or the new value
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < CAP; i++) begin
        case (cmd_i.op)
          plst_pkg::OP_APPEND: begin
            if (count_q == CNT_W'(i)) mem_q[i] <= value_q;
          end
          plst_pkg::OP_INSERT: begin
            if (pos_q == POS_W'(i + 1)) mem_q[i] <= value_q;
            else if (pos_q < POS_W'(i + 1)) mem_q[i] <= mem_q[(i > 0) ? i - 1 : 0];
          end
          plst_pkg::OP_ERASE: begin
            if (pos_q <= POS_W'(i + 1)) mem_q[i] <= mem_q[(i < CAP - 1) ? i + 1 : i];
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      plst_pkg::OP_APPEND,
      plst_pkg::OP_INSERT: count_d = count_q + CNT_W'(1);
      plst_pkg::OP_POP,
      plst_pkg::OP_ERASE:  count_d = count_q - CNT_W'(1);
      default:             count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      read_value_q <= (cmd_i.op == plst_pkg::OP_READ) ? rd_ext : '0;
      status_q     <= cmd_i.status;
    end
  end

  assign read_value_o  = signed'(read_value_q);
  assign entry_count_o = count_q;
  assign status_o      = status_q;

endmodule

// ===== sv/positional_list_store_core.sv =====
// Top level of the positional list store: controller plus datapath.
// Response: an accepted request is captured into the request registers, then
//   executed once the response register is free, which raises response valid.
// Requests are accepted only in idle, and each is captured and executed before
//   the next is taken; execute waits while a previous response is still held.
// Every list operation, including shifts, completes in the execute step.
// Reset (rst_ni low, async) empties the list and drops any pending response;
//   entry storage is not cleared since entries past the count are never read.
module positional_list_store_core #(
  parameter int ELEMENT_WIDTH = plst_pkg::ELEMENT_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  plst_req_if.sink        req_i,
  plst_rsp_if.source      rsp_o
);

  plst_pkg::cmd_t  cmd;
  plst_pkg::stat_t stat;

  // Controller: accepts a request in idle, then issues the decoded
  // operation once the response register is free (or being drained).
  plst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: holds the captured request, the entry cells that shift as a
  // chain for insert/erase, the count and the response payload.
  plst_dp #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (req_i.mode),
    .position_i    (req_i.position),
    .value_i       (req_i.value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .read_value_o  (rsp_o.read_value),
    .entry_count_o (rsp_o.entry_count),
    .status_o      (rsp_o.status)
  );

endmodule

// ===== sv/plst_checker.sv =====
// Port-level checker for the positional list store, bound to the top level.
module plst_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 rsp_valid_i,
  input logic                                 rsp_ready_i,
  input logic signed [plst_pkg::DATA_W-1:0]   read_value_i,
  input logic [plst_pkg::COUNT_W-1:0]         entry_count_i,
  input logic [plst_pkg::STATUS_W-1:0]        status_i
);

  localparam logic [plst_pkg::COUNT_W-1:0] CAP_CNT =
    plst_pkg::COUNT_W'(plst_pkg::CAPACITY);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> entry_count_i <= CAP_CNT)
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == plst_pkg::STATUS_FULL |-> entry_count_i == CAP_CNT)
    else $error("full status on a list that is not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == plst_pkg::STATUS_EMPTY |-> entry_count_i == '0)
    else $error("empty status on a list that is not empty");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && read_value_i != '0 |-> status_i == plst_pkg::STATUS_OK)
    else $error("nonzero read value with error status");

endmodule

bind positional_list_store_core plst_checker u_plst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .read_value_i  (rsp_o.read_value),
  .entry_count_i (rsp_o.entry_count),
  .status_i      (rsp_o.status)
);
